// File: hw/rtl/mobius_pkg.sv
package mobius_pkg;

	// Fixed-point format and the widths that follow from it
	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;                  // field and register width
	localparam int PW        = 2 * DW;              // full coefficient product
	localparam int FW        = PW - FRAC_BITS;      // product after the floor shift
	localparam int EW        = FW + 2;              // numerator / denominator parts
	localparam int LW        = EW / 2;              // low split of an operand
	localparam int HW        = EW - LW;             // high split of an operand
	localparam int MW        = 2 * EW + 1;          // squared magnitude and cross sums
	localparam int QW        = DW + 1;              // quotient bits developed
	localparam int RW        = MW + QW;             // divider remainder width
	localparam int NPROD     = 6;                   // wide products per point

	// Configuration register indexes
	localparam logic [2:0] REG_A_RE = 3'd0;
	localparam logic [2:0] REG_A_IM = 3'd1;
	localparam logic [2:0] REG_B_RE = 3'd2;
	localparam logic [2:0] REG_B_IM = 3'd3;
	localparam logic [2:0] REG_C_RE = 3'd4;
	localparam logic [2:0] REG_C_IM = 3'd5;
	localparam logic [2:0] REG_D_RE = 3'd6;
	localparam logic [2:0] REG_D_IM = 3'd7;

	localparam logic signed [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

	localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

endpackage

// File: hw/rtl/mobius_point_map.sv
// Mobius point map: w = (a*z + b) / (c*z + d), signed Q16.16.
// Input channel s_axis: one point z per word, tdata = {z_im, z_re}.
// Output channel m_axis: one mapped point per word, tdata = {w_im, w_re},
// tuser = {saturated, at_infinity}.
// Coefficients are written through cfg_we / cfg_idx / cfg_data, register i at
// index i, while no point is in flight; reset loads a = d = 1.0, b = c = 0.
// The datapath has forty register stages: five arithmetic stages (products,
// sums, partial products, cross sums, magnitude), a 34-stage restoring divider
// (an entry stage that flags oversized quotients, then one quotient bit a stage
// for both parts in parallel) and the output register. The first stage loads
// at the accepting edge. Throughput is one point per cycle while the receiver
// takes every word. The whole pipeline advances together when the output
// register is empty or taken; when the receiver stalls the pipeline holds and
// s_axis_tready drops, so no word is lost or repeated.
// Reset clears every valid bit asynchronously; the output is empty after reset.
module mobius_point_map
	import mobius_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [63:0]   s_axis_tdata,   // [31:0] z_re, [63:32] z_im
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,   // [31:0] w_re, [63:32] w_im
	output logic [1:0]    m_axis_tuser,   // [0] at_infinity, [1] saturated
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [DW-1:0] cfg_data
);

	logic adv;
	logic in_acc;

	// Coefficient registers
	logic signed [DW-1:0] coef_q [8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_A_RE] <= ONE_Q;
			coef_q[REG_A_IM] <= '0;
			coef_q[REG_B_RE] <= '0;
			coef_q[REG_B_IM] <= '0;
			coef_q[REG_C_RE] <= '0;
			coef_q[REG_C_IM] <= '0;
			coef_q[REG_D_RE] <= ONE_Q;
			coef_q[REG_D_IM] <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_A_RE: coef_q[REG_A_RE] <= cfg_data;
				REG_A_IM: coef_q[REG_A_IM] <= cfg_data;
				REG_B_RE: coef_q[REG_B_RE] <= cfg_data;
				REG_B_IM: coef_q[REG_B_IM] <= cfg_data;
				REG_C_RE: coef_q[REG_C_RE] <= cfg_data;
				REG_C_IM: coef_q[REG_C_IM] <= cfg_data;
				REG_D_RE: coef_q[REG_D_RE] <= cfg_data;
				REG_D_IM: coef_q[REG_D_IM] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline when the output word is empty or taken
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign in_acc        = s_axis_tvalid && adv;

	logic signed [DW-1:0] zr, zi;
	assign zr = s_axis_tdata[DW-1:0];
	assign zi = s_axis_tdata[2*DW-1:DW];

	// Valid bits for every stage
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic v_d [QW+1];

	// Stage 1: coefficient products
	logic signed [PW-1:0] prod_s1 [8];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[0] <= PW'(coef_q[REG_A_RE]) * PW'(zr);
			prod_s1[1] <= PW'(coef_q[REG_A_IM]) * PW'(zi);
			prod_s1[2] <= PW'(coef_q[REG_A_RE]) * PW'(zi);
			prod_s1[3] <= PW'(coef_q[REG_A_IM]) * PW'(zr);
			prod_s1[4] <= PW'(coef_q[REG_C_RE]) * PW'(zr);
			prod_s1[5] <= PW'(coef_q[REG_C_IM]) * PW'(zi);
			prod_s1[6] <= PW'(coef_q[REG_C_RE]) * PW'(zi);
			prod_s1[7] <= PW'(coef_q[REG_C_IM]) * PW'(zr);
		end
	end

	// Stage 2: floor-shift the products and sum into numerator and denominator
	logic signed [FW-1:0] fl [8];
	logic signed [EW-1:0] nr_s2, ni_s2, er_s2, ei_s2;

	always_comb begin
		for (int i = 0; i < 8; i++) fl[i] = FW'(prod_s1[i] >>> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s2 <= EW'(fl[0]) - EW'(fl[1]) + EW'(coef_q[REG_B_RE]);
			ni_s2 <= EW'(fl[2]) + EW'(fl[3]) + EW'(coef_q[REG_B_IM]);
			er_s2 <= EW'(fl[4]) - EW'(fl[5]) + EW'(coef_q[REG_D_RE]);
			ei_s2 <= EW'(fl[6]) + EW'(fl[7]) + EW'(coef_q[REG_D_IM]);
		end
	end

	// Stage 3: split each wide product into four narrow partial products
	logic signed [EW-1:0]   opx [NPROD];
	logic signed [EW-1:0]   opy [NPROD];
	logic signed [2*HW-1:0]    hh_s3 [NPROD];
	logic signed [HW+LW:0]     hl_s3 [NPROD];
	logic signed [HW+LW:0]     lh_s3 [NPROD];
	logic signed [2*LW+1:0]    ll_s3 [NPROD];
	logic                      inf_s3;

	always_comb begin
		opx[0] = er_s2; opy[0] = er_s2;
		opx[1] = ei_s2; opy[1] = ei_s2;
		opx[2] = nr_s2; opy[2] = er_s2;
		opx[3] = ni_s2; opy[3] = ei_s2;
		opx[4] = ni_s2; opy[4] = er_s2;
		opx[5] = nr_s2; opy[5] = ei_s2;
	end

	for (genvar g = 0; g < NPROD; g++) begin : g_pp
		logic signed [HW-1:0] xh, yh;
		logic signed [LW:0]   xl, yl;
		assign xh = opx[g][EW-1:LW];
		assign yh = opy[g][EW-1:LW];
		assign xl = {1'b0, opx[g][LW-1:0]};
		assign yl = {1'b0, opy[g][LW-1:0]};
		always_ff @(posedge clk) begin
			if (adv) begin
				hh_s3[g] <= (2*HW)'(xh) * (2*HW)'(yh);
				hl_s3[g] <= (HW+LW+1)'(xh) * (HW+LW+1)'(yl);
				lh_s3[g] <= (HW+LW+1)'(xl) * (HW+LW+1)'(yh);
				ll_s3[g] <= (2*LW+2)'(xl) * (2*LW+2)'(yl);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) inf_s3 <= (er_s2 == '0) && (ei_s2 == '0);
	end

	// Stage 4: recombine partials into magnitude squared and cross sums
	logic signed [MW-1:0] full [NPROD];
	logic signed [MW-1:0] m_s4, pr_s4, pi_s4;
	logic                 inf_s4;

	always_comb begin
		for (int i = 0; i < NPROD; i++) begin
			full[i] = (MW'(hh_s3[i]) <<< (2*LW)) + (MW'(hl_s3[i]) <<< LW)
			        + (MW'(lh_s3[i]) <<< LW) + MW'(ll_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s4   <= full[0] + full[1];
			pr_s4  <= full[2] + full[3];
			pi_s4  <= full[4] - full[5];
			inf_s4 <= inf_s3;
		end
	end

	// Stage 5: magnitude of the dividends, scaled by the fraction bits
	logic [RW-1:0] a_re_s5, a_im_s5, m_s5;
	logic          neg_re_s5, neg_im_s5, inf_s5;
	logic [MW-1:0] mag_re, mag_im;

	assign mag_re = pr_s4[MW-1] ? MW'(-pr_s4) : MW'(pr_s4);
	assign mag_im = pi_s4[MW-1] ? MW'(-pi_s4) : MW'(pi_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_re_s5   <= RW'(mag_re) << FRAC_BITS;
			a_im_s5   <= RW'(mag_im) << FRAC_BITS;
			m_s5      <= RW'(m_s4);
			neg_re_s5 <= pr_s4[MW-1];
			neg_im_s5 <= pi_s4[MW-1];
			inf_s5    <= inf_s4;
		end
	end

	// Divider: entry stage flags quotients of 2^QW or more, then one bit a stage
	logic [RW-1:0] rem_re_s [QW+1];
	logic [RW-1:0] rem_im_s [QW+1];
	logic [RW-1:0] dm_s     [QW+1];
	logic [QW-1:0] q_re_s   [QW+1];
	logic [QW-1:0] q_im_s   [QW+1];
	logic          ovf_re_s [QW+1];
	logic          ovf_im_s [QW+1];
	logic          neg_re_s [QW+1];
	logic          neg_im_s [QW+1];
	logic          inf_s    [QW+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_re_s[0] <= a_re_s5;
			rem_im_s[0] <= a_im_s5;
			dm_s[0]     <= m_s5;
			q_re_s[0]   <= '0;
			q_im_s[0]   <= '0;
			ovf_re_s[0] <= a_re_s5 >= (m_s5 << QW);
			ovf_im_s[0] <= a_im_s5 >= (m_s5 << QW);
			neg_re_s[0] <= neg_re_s5;
			neg_im_s[0] <= neg_im_s5;
			inf_s[0]    <= inf_s5;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int K = QW - j;
		logic [RW-1:0] sh;
		logic          ge_re, ge_im;
		assign sh    = dm_s[j-1] << K;
		assign ge_re = rem_re_s[j-1] >= sh;
		assign ge_im = rem_im_s[j-1] >= sh;
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_re_s[j]    <= ge_re ? rem_re_s[j-1] - sh : rem_re_s[j-1];
				rem_im_s[j]    <= ge_im ? rem_im_s[j-1] - sh : rem_im_s[j-1];
				q_re_s[j]      <= q_re_s[j-1] | (QW'(ge_re) << K);
				q_im_s[j]      <= q_im_s[j-1] | (QW'(ge_im) << K);
				dm_s[j]        <= dm_s[j-1];
				ovf_re_s[j]    <= ovf_re_s[j-1];
				ovf_im_s[j]    <= ovf_im_s[j-1];
				neg_re_s[j]    <= neg_re_s[j-1];
				neg_im_s[j]    <= neg_im_s[j-1];
				inf_s[j]       <= inf_s[j-1];
			end
		end
	end

	// Output stage: apply sign, clamp to range, force zero at infinity
	logic [QW-1:0] qr, qi;
	logic          sat_re, sat_im;
	logic [DW-1:0] w_re_n, w_im_n;
	logic [DW-1:0] w_re_q, w_im_q;
	logic          at_inf_q, sat_q;

	assign qr = q_re_s[QW];
	assign qi = q_im_s[QW];

	always_comb begin
		if (neg_re_s[QW]) begin
			sat_re = ovf_re_s[QW] || qr[QW-1] || (qr[DW-1] && (qr[DW-2:0] != '0));
			w_re_n = sat_re ? SAT_NEG : DW'(-qr[DW-1:0]);
		end else begin
			sat_re = ovf_re_s[QW] || qr[QW-1] || qr[DW-1];
			w_re_n = sat_re ? SAT_POS : qr[DW-1:0];
		end
		if (neg_im_s[QW]) begin
			sat_im = ovf_im_s[QW] || qi[QW-1] || (qi[DW-1] && (qi[DW-2:0] != '0));
			w_im_n = sat_im ? SAT_NEG : DW'(-qi[DW-1:0]);
		end else begin
			sat_im = ovf_im_s[QW] || qi[QW-1] || qi[DW-1];
			w_im_n = sat_im ? SAT_POS : qi[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_re_q   <= inf_s[QW] ? '0 : w_re_n;
			w_im_q   <= inf_s[QW] ? '0 : w_im_n;
			at_inf_q <= inf_s[QW];
			sat_q    <= !inf_s[QW] && (sat_re || sat_im);
		end
	end

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i <= QW; i++) v_d[i] <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_d[0] <= v_s5;
			for (int i = 1; i <= QW; i++) v_d[i] <= v_d[i-1];
			m_axis_tvalid <= v_d[QW];
		end
	end

	assign m_axis_tdata = {w_im_q, w_re_q};
	assign m_axis_tuser = {sat_q, at_inf_q};

	// A point at infinity carries zero data and no clamp
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
		else $error("point at infinity with nonzero data or clamp flag");

	// Remainder left by the divider stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_d[QW] && !inf_s[QW] && !ovf_re_s[QW] && !ovf_im_s[QW]
		|-> (rem_re_s[QW] < dm_s[QW]) && (rem_im_s[QW] < dm_s[QW]))
		else $error("divider remainder not below divisor");

	// A stalled output word is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

endmodule

// File: tb/mobius_point_map_test.sv
module mobius_point_map_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mobius_pkg::*;

	typedef struct packed {
		logic [31:0] w_re;
		logic [31:0] w_im;
		logic        at_inf;
		logic        sat;
	} mapped_point_t;

	// Mapped points expected from the block, oldest first
	class point_map_board;
		logic signed [31:0] coef[8];
		mapped_point_t      pending[$];
		int                 fails;

		function new();
			foreach (coef[i]) coef[i] = '0;
			coef[REG_A_RE] = ONE_Q;
			coef[REG_D_RE] = ONE_Q;
			fails = 0;
		endfunction

		// floored Q16.16 product
		function logic signed [63:0] fmul(logic signed [31:0] x, logic signed [31:0] y);
			logic signed [63:0] p;
			p = 64'(x) * 64'(y);
			return p >>> FRAC_BITS;
		endfunction

		function logic [31:0] clamp(logic signed [159:0] q, inout logic sat);
			if (q > 160'sh7fffffff) begin
				sat = 1'b1;
				return SAT_POS;
			end
			if (q < -160'sh80000000) begin
				sat = 1'b1;
				return SAT_NEG;
			end
			return q[31:0];
		endfunction

		// Predict the mapped point for an accepted word
		function void note_point(logic signed [31:0] zr, logic signed [31:0] zi);
			logic signed [63:0]  nr, ni, er, ei;
			logic signed [159:0] wnr, wni, wer, wei, m, pr, pim;
			mapped_point_t       r;
			nr = fmul(coef[REG_A_RE], zr) - fmul(coef[REG_A_IM], zi) + 64'(coef[REG_B_RE]);
			ni = fmul(coef[REG_A_RE], zi) + fmul(coef[REG_A_IM], zr) + 64'(coef[REG_B_IM]);
			er = fmul(coef[REG_C_RE], zr) - fmul(coef[REG_C_IM], zi) + 64'(coef[REG_D_RE]);
			ei = fmul(coef[REG_C_RE], zi) + fmul(coef[REG_C_IM], zr) + 64'(coef[REG_D_IM]);
			r = '0;
			if (er == 0 && ei == 0) begin
				r.at_inf = 1'b1;
			end else begin
				wnr = nr; wni = ni; wer = er; wei = ei;
				m   = wer * wer + wei * wei;
				pr  = wnr * wer + wni * wei;
				pim = wni * wer - wnr * wei;
				r.w_re = clamp((pr <<< FRAC_BITS) / m, r.sat);
				r.w_im = clamp((pim <<< FRAC_BITS) / m, r.sat);
			end
			pending.push_back(r);
		endfunction

		// Compare a delivered word with the oldest prediction
		function void check_point(mapped_point_t got);
			mapped_point_t exp_p;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				fails++;
				return;
			end
			exp_p = pending.pop_front();
			if (got.w_re !== exp_p.w_re) begin
				$display("%0t: w_re exp %h got %h", $time, exp_p.w_re, got.w_re);
				fails++;
			end
			if (got.w_im !== exp_p.w_im) begin
				$display("%0t: w_im exp %h got %h", $time, exp_p.w_im, got.w_im);
				fails++;
			end
			if (got.at_inf !== exp_p.at_inf) begin
				$display("%0t: at_infinity exp %b got %b", $time, exp_p.at_inf, got.at_inf);
				fails++;
			end
			if (got.sat !== exp_p.sat) begin
				$display("%0t: saturated exp %b got %b", $time, exp_p.sat, got.sat);
				fails++;
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata = '0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [63:0]   m_axis_tdata;
	logic [1:0]    m_axis_tuser;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_idx = '0;
	logic [DW-1:0] cfg_data = '0;

	point_map_board board = new();
	int             idle_pct = 0;
	int             stall_pct = 0;

	mobius_point_map dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("[mobius_point_map] ERROR");
		$finish;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Collect delivered words
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_point({m_axis_tdata[31:0], m_axis_tdata[63:32],
				m_axis_tuser[0], m_axis_tuser[1]});
	end

	task automatic send_point(logic [31:0] zr, logic [31:0] zi);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {zi, zr};
		do @(posedge clk); while (!s_axis_tready);
		board.note_point(zr, zi);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	// Load all eight coefficients while the pipeline is empty
	task automatic load_coefs(logic [31:0] v[8]);
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= i[2:0];
			cfg_data <= v[i];
			@(posedge clk);
			board.coef[i] = v[i];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] small_q(int span);
		return 32'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic random_coefs();
		logic [31:0] v[8];
		int          style;
		style = $urandom_range(9);
		foreach (v[i]) v[i] = (style == 0) ? $urandom() : small_q(1 << 18);
		// sometimes leave d at zero so z = 0 lands on the pole
		if (style == 1) begin
			v[REG_D_RE] = '0;
			v[REG_D_IM] = '0;
		end
		load_coefs(v);
	endtask

	task automatic random_point();
		int kind;
		kind = $urandom_range(9);
		if (kind < 4)
			send_point($urandom(), $urandom());
		else if (kind < 9)
			send_point(small_q(1 << 19), small_q(1 << 19));
		else
			send_point('0, '0);
	endtask

	initial begin
		logic [31:0] v[8];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity map after reset, extremes of z
		send_point('0, '0);
		send_point(32'h7fffffff, 32'h80000000);
		send_point(32'h80000000, 32'h7fffffff);
		send_point(32'hffffffff, 32'h00000001);
		send_point(32'h00018000, 32'hfffe8000);

		// Pole: c = 1, d = 0, so z = 0 has a zero denominator
		v = '{32'h10000, 0, 32'h20000, 0, 32'h10000, 0, 0, 0};
		load_coefs(v);
		send_point('0, '0);
		send_point(32'h00000001, '0);
		send_point(32'hfff00000, 32'h00030000);

		// Saturation: huge a over tiny d
		v = '{32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 32'h00000001, 0};
		load_coefs(v);
		send_point(32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h00010000);
		send_point(32'h00010000, 32'h80000000);

		// Register extremes
		foreach (v[i]) v[i] = 32'h7fffffff;
		load_coefs(v);
		send_point(32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000);
		send_point(32'h00010000, '0);
		foreach (v[i]) v[i] = 32'h80000000;
		load_coefs(v);
		send_point(32'h7fffffff, 32'h80000000);
		send_point(32'h80000000, 32'h80000000);
		send_point('0, '0);

		// Random phases with different idling and back-pressure
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 85; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 85; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase
			for (int part = 0; part < 2; part++) begin
				random_coefs();
				for (int n = 0; n < 92; n++) begin
					if (ph == 1 && part == 0 && n == 45) begin
						s_axis_tvalid <= 1'b0;
						while (board.pending.size() != 0) @(posedge clk);
					end
					random_point();
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		stall_pct = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (board.fails == 0)
			$display("[mobius_point_map] OK");
		else
			$display("[mobius_point_map] ERROR");
		$finish;
	end

endmodule

// File: mobius_point_map.f
hw/rtl/mobius_pkg.sv
hw/rtl/mobius_point_map.sv
tb/mobius_point_map_test.sv
